// ===== hdl/light_level_duty_and_alert_top_defines.svh =====
// Assertion macros shared by the light level duty and alert RTL.
// Users include this header; the macros expect aclk and aresetn in scope.
`ifndef LIGHT_LEVEL_DUTY_AND_ALERT_TOP_DEFINES_SVH
`define LIGHT_LEVEL_DUTY_AND_ALERT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LLDA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LLDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/llda_pkg.sv =====
// Shared types and constants for the light level duty and alert block.
// Used by llda_ctrl, llda_dp and light_level_duty_and_alert_top; no dependencies.
`default_nettype none

package llda_pkg;

    // Field widths fixed by the sample and register formats.
    localparam int MV_W       = 12;
    localparam int HOLD_W     = 8;
    localparam int IN_TDATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BAND     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BAND    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DARK_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_COUNT   = 3'd5;

    // Register reset values.
    localparam logic [MV_W-1:0]   RST_FULL_SCALE   = 12'd3300;
    localparam logic [MV_W-1:0]   RST_LOW_BAND     = 12'd990;
    localparam logic [MV_W-1:0]   RST_HIGH_BAND    = 12'd2310;
    localparam logic [MV_W-1:0]   RST_DARK_LIMIT   = 12'd165;
    localparam logic [MV_W-1:0]   RST_BRIGHT_LIMIT = 12'd3135;
    localparam logic [HOLD_W-1:0] RST_HOLD_COUNT   = 8'd10;

    // Brightness band codes.
    localparam logic [1:0] BAND_LOW  = 2'd0;
    localparam logic [1:0] BAND_MID  = 2'd1;
    localparam logic [1:0] BAND_HIGH = 2'd2;

    // Alert level codes.
    localparam logic [1:0] LEVEL_NONE   = 2'd0;
    localparam logic [1:0] LEVEL_DARK   = 2'd1;
    localparam logic [1:0] LEVEL_BRIGHT = 2'd2;

    // Configuration register set.
    typedef struct packed {
        logic [MV_W-1:0]   full_scale;
        logic [MV_W-1:0]   low_band;
        logic [MV_W-1:0]   high_band;
        logic [MV_W-1:0]   dark_limit;
        logic [MV_W-1:0]   bright_limit;
        logic [HOLD_W-1:0] hold_count;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture and clamp a new sample, set up the divider
        logic step;    // one restoring division step
        logic commit;  // update runs and level, write the result register
    } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/llda_dp.sv =====
// Datapath: clamp, bit-serial duty divider, band, run counters and alert level.
// Depends on llda_pkg; driven by commands from llda_ctrl.
`default_nettype none

module llda_dp #(
    parameter int DUTY_BITS = 13,
    parameter int OUT_W     = 24
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire llda_pkg::cmd_t                  cmd,
    input  wire llda_pkg::cfg_t                  cfg,
    input  wire logic [llda_pkg::MV_W-1:0]       sample_mv,
    output logic      [OUT_W-1:0]                out_data
);

    localparam int MV_W   = llda_pkg::MV_W;
    localparam int HOLD_W = llda_pkg::HOLD_W;
    localparam int PROD_W = MV_W + DUTY_BITS;

    logic [MV_W-1:0]      mv_reg;
    logic [MV_W-1:0]      rem_reg, rem_next;
    logic [DUTY_BITS-1:0] shf_reg, shf_next;
    logic [HOLD_W-1:0]    dark_run_reg, dark_run_next;
    logic [HOLD_W-1:0]    bright_run_reg, bright_run_next;
    logic [1:0]           last_level_reg, level_next;
    logic [DUTY_BITS-1:0] duty_out_reg, duty_next;
    logic [1:0]           band_out_reg, band_next;
    logic [1:0]           level_out_reg;
    logic                 raised_out_reg, raised_next;

    logic [MV_W-1:0]      clamp_mv;
    logic [PROD_W-1:0]    prod;
    logic [MV_W:0]        trial;
    logic                 trial_ge;
    logic                 is_dark, is_bright;

    // Clamp the sample and form mv * (2^DUTY_BITS - 1) by shift and subtract.
    always_comb begin
        clamp_mv = (sample_mv > cfg.full_scale) ? cfg.full_scale : sample_mv;
        prod     = {clamp_mv, {DUTY_BITS{1'b0}}} - PROD_W'(clamp_mv);
    end

    // Restoring division step: the partial remainder stays below full scale,
    // and quotient bits shift in where dividend bits shift out.
    always_comb begin
        trial    = {rem_reg, shf_reg[DUTY_BITS-1]};
        trial_ge = (trial >= {1'b0, cfg.full_scale});
        rem_next = trial_ge ? MV_W'(trial - {1'b0, cfg.full_scale}) : trial[MV_W-1:0];
        shf_next = {shf_reg[DUTY_BITS-2:0], trial_ge};
    end

    // Band, run counters and alert level for the clamped sample.
    always_comb begin
        is_dark   = (mv_reg <= cfg.dark_limit);
        is_bright = (mv_reg >= cfg.bright_limit);

        if (mv_reg < cfg.low_band) begin
            band_next = llda_pkg::BAND_LOW;
        end else if (mv_reg > cfg.high_band) begin
            band_next = llda_pkg::BAND_HIGH;
        end else begin
            band_next = llda_pkg::BAND_MID;
        end

        dark_run_next   = '0;
        bright_run_next = '0;
        level_next      = llda_pkg::LEVEL_NONE;
        if (is_dark) begin
            dark_run_next = (dark_run_reg < cfg.hold_count) ? dark_run_reg + 1'b1
                                                            : cfg.hold_count;
            if (dark_run_next >= cfg.hold_count) begin
                level_next = llda_pkg::LEVEL_DARK;
            end
        end else if (is_bright) begin
            bright_run_next = (bright_run_reg < cfg.hold_count) ? bright_run_reg + 1'b1
                                                                : cfg.hold_count;
            if (bright_run_next >= cfg.hold_count) begin
                level_next = llda_pkg::LEVEL_BRIGHT;
            end
        end

        raised_next = (level_next != llda_pkg::LEVEL_NONE) && (level_next != last_level_reg);

        // A zero full scale clamps everything to zero, so the duty is zero.
        duty_next = (cfg.full_scale == '0) ? '0 : shf_reg;
    end

    // Divider and result registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mv_reg  <= clamp_mv;
            rem_reg <= prod[PROD_W-1:DUTY_BITS];
            shf_reg <= prod[DUTY_BITS-1:0];
        end else if (cmd.step) begin
            rem_reg <= rem_next;
            shf_reg <= shf_next;
        end
        if (cmd.commit) begin
            duty_out_reg   <= duty_next;
            band_out_reg   <= band_next;
            level_out_reg  <= level_next;
            raised_out_reg <= raised_next;
        end
    end

    // Run and level state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dark_run_reg   <= '0;
            bright_run_reg <= '0;
            last_level_reg <= llda_pkg::LEVEL_NONE;
        end else if (cmd.commit) begin
            dark_run_reg   <= dark_run_next;
            bright_run_reg <= bright_run_next;
            last_level_reg <= level_next;
        end
    end

    // Result packing, duty in the lowest bits.
    assign out_data = OUT_W'({raised_out_reg, level_out_reg, band_out_reg, duty_out_reg});

endmodule

`default_nettype wire

// ===== hdl/llda_ctrl.sv =====
// Controller: accepts a sample, sequences the division steps, commits the result.
// Depends on llda_pkg and light_level_duty_and_alert_top_defines.svh.
`default_nettype none

`include "light_level_duty_and_alert_top_defines.svh"

module llda_ctrl #(
    parameter int DUTY_BITS = 13
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output llda_pkg::cmd_t      cmd
);

    localparam int CNT_W = $clog2(DUTY_BITS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             s_fire;
    logic             can_commit;

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_fire     = s_tvalid && s_tready;
    assign can_commit = !out_valid_reg || m_tready;
    assign m_tvalid   = out_valid_reg;

    // Commands follow the state; the result is committed once the output slot frees.
    always_comb begin
        cmd.load   = s_fire;
        cmd.step   = (state_reg == ST_DIV);
        cmd.commit = (state_reg == ST_DONE) && can_commit;
    end

    // Next state, step count and output valid.
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DUTY_BITS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (can_commit) begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // An accepted sample starts the divider from step zero.
    `LLDA_ASSERT_NEXT(a_accept_starts_div, s_fire, (state_reg == ST_DIV) && (cnt_reg == '0), "accepted sample did not start the divider")
    // The divider has run all its steps before a result is committed.
    `LLDA_ASSERT_NOW(a_commit_after_steps, cmd.commit, cnt_reg == CNT_W'(DUTY_BITS), "result committed before all division steps")
    // A commit never overwrites a result that is still waiting.
    `LLDA_ASSERT_NOW(a_no_overwrite, cmd.commit, !out_valid_reg || m_tready, "pending result overwritten")

endmodule

`default_nettype wire

// ===== hdl/light_level_duty_and_alert_top.sv =====
// Top level of the light level duty and alert block: configuration registers,
// controller and datapath. Depends on llda_pkg, llda_ctrl and llda_dp.
//
//  Channel   Direction  Handshake            Payload
//  s_        in         s_tvalid/s_tready    s_tdata[11:0] sample_mv
//  m_        out        m_tvalid/m_tready    m_tdata: duty, band, alert_level, alert_raised
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each sample is accepted and clamped, then run through DUTY_BITS steps of the bit-serial
// restoring divider, and its result is then committed.
// The finished result sits in an output register, so a new sample is taken while
// it waits; a stalled result only holds the commit of the following sample.
// Reset is synchronous and active low: configuration registers return to their defaults
// and the run counters and stored alert level clear. Configuration writes are always taken.
`default_nettype none

module light_level_duty_and_alert_top #(
    parameter int DUTY_BITS = 13
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // Sample transactions.
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [llda_pkg::IN_TDATA_W-1:0]      s_tdata,   // [11:0] sample_mv
    // Result transactions.
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [((DUTY_BITS + 5 + 7) / 8) * 8-1:0]  m_tdata,   // duty, band (2),
                                                                 // alert_level (2),
                                                                 // alert_raised (1)
    // Configuration writes.
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [llda_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [llda_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int OUT_W = ((DUTY_BITS + 5 + 7) / 8) * 8;

    llda_pkg::cfg_t cfg_reg;
    llda_pkg::cmd_t cmd;
    logic           cfg_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // Configuration register file; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.full_scale   <= llda_pkg::RST_FULL_SCALE;
            cfg_reg.low_band     <= llda_pkg::RST_LOW_BAND;
            cfg_reg.high_band    <= llda_pkg::RST_HIGH_BAND;
            cfg_reg.dark_limit   <= llda_pkg::RST_DARK_LIMIT;
            cfg_reg.bright_limit <= llda_pkg::RST_BRIGHT_LIMIT;
            cfg_reg.hold_count   <= llda_pkg::RST_HOLD_COUNT;
        end else if (cfg_fire) begin
            case (cfg_index)
                llda_pkg::CFG_FULL_SCALE:   cfg_reg.full_scale   <= cfg_data;
                llda_pkg::CFG_LOW_BAND:     cfg_reg.low_band     <= cfg_data;
                llda_pkg::CFG_HIGH_BAND:    cfg_reg.high_band    <= cfg_data;
                llda_pkg::CFG_DARK_LIMIT:   cfg_reg.dark_limit   <= cfg_data;
                llda_pkg::CFG_BRIGHT_LIMIT: cfg_reg.bright_limit <= cfg_data;
                llda_pkg::CFG_HOLD_COUNT:
                    cfg_reg.hold_count <= cfg_data[llda_pkg::HOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencing of one sample.
    llda_ctrl #(
        .DUTY_BITS (DUTY_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Arithmetic and state.
    llda_dp #(
        .DUTY_BITS (DUTY_BITS),
        .OUT_W     (OUT_W)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .cfg       (cfg_reg),
        .sample_mv (s_tdata[llda_pkg::MV_W-1:0]),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire
